### design/qvr_pkg.sv
// Shared types and widths for the quaternion vector rotation core.
`default_nettype none
package qvr_pkg;

  // Field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PROD_W = 2 * DATA_W;     // quaternion component product
  localparam int unsigned COEF_W = PROD_W + 2;     // rotation matrix entry, scaled by N
  localparam int unsigned DEN_W  = PROD_W + 1;     // squared norm, unsigned
  localparam int unsigned LO_W   = DATA_W;         // low slice of a matrix entry
  localparam int unsigned HI_W   = COEF_W - LO_W;  // high slice of a matrix entry
  localparam int unsigned TERM_W = COEF_W + DATA_W;
  localparam int unsigned NUM_W  = TERM_W + 2;     // sum of three terms
  localparam int unsigned QUO_W  = DATA_W;

  // Register map, index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_REAL = 2'd0,
    REG_I    = 2'd1,
    REG_J    = 2'd2,
    REG_K    = 2'd3
  } qvr_reg_e;

  localparam logic [DATA_W-1:0] QUAT_REAL_RST = 32'h1000_0000;
  localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

  // One rotated component leaving a divider lane
  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              sat;
    logic              zero;
  } qvr_res_t;

endpackage
`default_nettype wire

### design/qvr_div.sv
// Pipelined restoring divider: rounded, saturated quotient of one component.
`default_nettype none
module qvr_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             en_i,
  input  wire logic                             valid_i,
  input  wire logic signed [qvr_pkg::NUM_W-1:0] num_i,
  input  wire logic        [qvr_pkg::DEN_W-1:0] den_i,
  input  wire logic                             zero_i,
  output logic                                  valid_o,
  output qvr_pkg::qvr_res_t                     res_o
);

  localparam int unsigned NW = qvr_pkg::NUM_W;
  localparam int unsigned DW = qvr_pkg::DEN_W;
  localparam int unsigned QW = qvr_pkg::QUO_W;

  // Stage k holds the partial remainder after k quotient bits
  logic          vld_q  [QW+1];
  logic [NW-1:0] rem_q  [QW+1];
  logic [QW-1:0] quo_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic          neg_q  [QW+1];
  logic          zero_q [QW+1];
  logic          ovf_q  [QW+1];

  logic [NW-1:0] mag;
  logic [NW-1:0] den_top;

  // Entry: magnitude and overflow check against den * 2^32
  always_comb begin
    mag     = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    den_top = NW'({den_i, {QW{1'b0}}});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= mag;
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      neg_q[0]  <= num_i[NW-1];
      zero_q[0] <= zero_i;
      ovf_q[0]  <= (mag >= den_top);
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [NW-1:0] sub;
    logic          ge;

    always_comb begin
      sub = NW'(den_q[k]) << (QW - 1 - k);
      ge  = (rem_q[k] >= sub);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? (rem_q[k] - sub) : rem_q[k];
        quo_q[k+1]  <= {quo_q[k][QW-2:0], ge};
        den_q[k+1]  <= den_q[k];
        neg_q[k+1]  <= neg_q[k];
        zero_q[k+1] <= zero_q[k];
        ovf_q[k+1]  <= ovf_q[k];
      end
    end
  end

  // Round half away from zero, then clamp
  logic [DW-1:0] rem_lo;
  logic          up;
  logic [QW:0]   quo_rnd;
  qvr_pkg::qvr_res_t res_d;
  qvr_pkg::qvr_res_t res_q;
  logic          out_vld_q;

  always_comb begin
    rem_lo  = rem_q[QW][DW-1:0];  // remainder is below the divisor
    up      = ({rem_lo, 1'b0} >= {1'b0, den_q[QW]});
    quo_rnd = {1'b0, quo_q[QW]} + (QW+1)'(up);
    res_d.zero = zero_q[QW];
    res_d.sat  = 1'b0;
    res_d.value = '0;
    if (zero_q[QW]) begin
      res_d.value = '0;
    end else if (!neg_q[QW]) begin
      if (ovf_q[QW] || (quo_rnd > (QW+1)'(qvr_pkg::SAT_POS))) begin
        res_d.value = qvr_pkg::SAT_POS;
        res_d.sat   = 1'b1;
      end else begin
        res_d.value = quo_rnd[QW-1:0];
      end
    end else begin
      if (ovf_q[QW] || (quo_rnd > (QW+1)'(qvr_pkg::SAT_NEG))) begin
        res_d.value = qvr_pkg::SAT_NEG;
        res_d.sat   = 1'b1;
      end else begin
        res_d.value = QW'(-quo_rnd[QW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = out_vld_q;
  assign res_o   = res_q;

endmodule
`default_nettype wire

### design/quaternion_vector_rotation_core.sv
// Top level of the quaternion vector rotation core.
`default_nettype none
// Rotates each vector item (Q16.16) by the quaternion in the four APB registers
// (Q4.28, any nonzero length; the length cancels) and returns the vector part of
// q*(0,v)*conj(q)/|q|^2, rounded to nearest with ties away from zero and
// saturated to Q16.16. A zero quaternion gives a zero vector with zero_norm set.
// One item enters per cycle while the output is not stalled. The pipeline has five
// stages of products, matrix entries, split multiplies, recombine and sum, then a
// 34-stage divider lane per component (magnitude, 32 quotient bits, round and clamp).
// The whole pipeline holds while a finished item waits at the output. Registers may
// be written only when no item is in flight.
module quaternion_vector_rotation_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] in_x_i,
  input  wire logic [31:0] in_y_i,
  input  wire logic [31:0] in_z_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      out_x_o,
  output logic [31:0]      out_y_o,
  output logic [31:0]      out_z_o,
  output logic             zero_norm_o,
  output logic             saturated_o
);

  localparam int unsigned DW  = qvr_pkg::DATA_W;
  localparam int unsigned PW  = qvr_pkg::PROD_W;
  localparam int unsigned CW  = qvr_pkg::COEF_W;
  localparam int unsigned NDW = qvr_pkg::DEN_W;
  localparam int unsigned LW  = qvr_pkg::LO_W;
  localparam int unsigned HW  = qvr_pkg::HI_W;
  localparam int unsigned TW  = qvr_pkg::TERM_W;
  localparam int unsigned NW  = qvr_pkg::NUM_W;

  // Configuration registers
  logic [DW-1:0] quat_q [4];
  logic          wr_en;
  qvr_pkg::qvr_reg_e wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = qvr_pkg::qvr_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q[qvr_pkg::REG_REAL] <= qvr_pkg::QUAT_REAL_RST;
      quat_q[qvr_pkg::REG_I]    <= '0;
      quat_q[qvr_pkg::REG_J]    <= '0;
      quat_q[qvr_pkg::REG_K]    <= '0;
    end else if (wr_en) begin
      case (wr_idx)
        qvr_pkg::REG_REAL: quat_q[qvr_pkg::REG_REAL] <= pwdata;
        qvr_pkg::REG_I:    quat_q[qvr_pkg::REG_I]    <= pwdata;
        qvr_pkg::REG_J:    quat_q[qvr_pkg::REG_J]    <= pwdata;
        qvr_pkg::REG_K:    quat_q[qvr_pkg::REG_K]    <= pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (wr_idx)
      qvr_pkg::REG_REAL: prdata = quat_q[qvr_pkg::REG_REAL];
      qvr_pkg::REG_I:    prdata = quat_q[qvr_pkg::REG_I];
      qvr_pkg::REG_J:    prdata = quat_q[qvr_pkg::REG_J];
      qvr_pkg::REG_K:    prdata = quat_q[qvr_pkg::REG_K];
      default:           prdata = '0;
    endcase
  end

  // Global advance: the whole pipeline holds while the output waits
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  logic signed [DW-1:0] qw, qx, qy, qz;
  assign qw = quat_q[qvr_pkg::REG_REAL];
  assign qx = quat_q[qvr_pkg::REG_I];
  assign qy = quat_q[qvr_pkg::REG_J];
  assign qz = quat_q[qvr_pkg::REG_K];

  // Stage 1: quaternion component products
  logic                 s1_vld_q;
  logic signed [PW-1:0] ww_q, xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
  logic signed [DW-1:0] s1_v_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= PW'(qw) * PW'(qw);
      xx_q <= PW'(qx) * PW'(qx);
      yy_q <= PW'(qy) * PW'(qy);
      zz_q <= PW'(qz) * PW'(qz);
      xy_q <= PW'(qx) * PW'(qy);
      xz_q <= PW'(qx) * PW'(qz);
      yz_q <= PW'(qy) * PW'(qz);
      wx_q <= PW'(qw) * PW'(qx);
      wy_q <= PW'(qw) * PW'(qy);
      wz_q <= PW'(qw) * PW'(qz);
      s1_v_q[0] <= in_x_i;
      s1_v_q[1] <= in_y_i;
      s1_v_q[2] <= in_z_i;
    end
  end

  // Stage 2: rotation matrix scaled by the squared norm, and the norm
  logic                 s2_vld_q;
  logic signed [CW-1:0] m_q [9];
  logic signed [CW-1:0] m_d [9];
  logic signed [CW-1:0] n_d;
  logic signed [CW-1:0] s2_n_q;
  logic signed [DW-1:0] s2_v_q [3];

  always_comb begin
    m_d[0] = CW'(ww_q) + CW'(xx_q) - CW'(yy_q) - CW'(zz_q);
    m_d[1] = (CW'(xy_q) - CW'(wz_q)) <<< 1;
    m_d[2] = (CW'(xz_q) + CW'(wy_q)) <<< 1;
    m_d[3] = (CW'(xy_q) + CW'(wz_q)) <<< 1;
    m_d[4] = CW'(ww_q) - CW'(xx_q) + CW'(yy_q) - CW'(zz_q);
    m_d[5] = (CW'(yz_q) - CW'(wx_q)) <<< 1;
    m_d[6] = (CW'(xz_q) - CW'(wy_q)) <<< 1;
    m_d[7] = (CW'(yz_q) + CW'(wx_q)) <<< 1;
    m_d[8] = CW'(ww_q) - CW'(xx_q) - CW'(yy_q) + CW'(zz_q);
    n_d    = CW'(ww_q) + CW'(xx_q) + CW'(yy_q) + CW'(zz_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_q    <= m_d;
      s2_n_q <= n_d;
      s2_v_q <= s1_v_q;
    end
  end

  // Stage 3: each entry times its vector component, split into two slices
  logic                        s3_vld_q;
  logic signed [LW+DW:0]       plo_q [9];
  logic signed [HW+DW-1:0]     phi_q [9];
  logic signed [CW-1:0]        s3_n_q;

  for (genvar e = 0; e < 9; e++) begin : g_mul
    logic signed [LW:0]   lo_op;
    logic signed [HW-1:0] hi_op;
    assign lo_op = $signed({1'b0, m_q[e][LW-1:0]});
    assign hi_op = m_q[e][CW-1:LW];
    always_ff @(posedge clk_i) begin
      if (en) begin
        plo_q[e] <= (LW+DW+1)'(lo_op) * (LW+DW+1)'(s2_v_q[e % 3]);
        phi_q[e] <= (HW+DW)'(hi_op) * (HW+DW)'(s2_v_q[e % 3]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_n_q <= s2_n_q;
    end
  end

  // Stage 4: recombine slices into full terms
  logic                 s4_vld_q;
  logic signed [TW-1:0] term_q [9];
  logic signed [CW-1:0] s4_n_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int e = 0; e < 9; e++) begin
        term_q[e] <= (TW'(phi_q[e]) <<< LW) + TW'(plo_q[e]);
      end
      s4_n_q <= s3_n_q;
    end
  end

  // Stage 5: numerator of each component, zero-norm detect
  logic                  s5_vld_q;
  logic signed [NW-1:0]  num_q [3];
  logic        [NDW-1:0] s5_den_q;
  logic                  s5_zero_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        num_q[r] <= NW'(term_q[3*r]) + NW'(term_q[3*r+1]) + NW'(term_q[3*r+2]);
      end
      s5_den_q  <= s4_n_q[NDW-1:0];
      s5_zero_q <= (s4_n_q == '0);
    end
  end

  // Valid bits of the front stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  // Divider lanes, one per component
  logic              lane_vld [3];
  qvr_pkg::qvr_res_t lane_res [3];

  for (genvar r = 0; r < 3; r++) begin : g_lane
    qvr_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (s5_vld_q),
      .num_i   (num_q[r]),
      .den_i   (s5_den_q),
      .zero_i  (s5_zero_q),
      .valid_o (lane_vld[r]),
      .res_o   (lane_res[r])
    );
  end

  // Outputs; lanes run in lockstep
  assign out_valid_o = lane_vld[0] && lane_vld[1] && lane_vld[2];
  assign out_x_o     = lane_res[0].value;
  assign out_y_o     = lane_res[1].value;
  assign out_z_o     = lane_res[2].value;
  assign zero_norm_o = lane_res[0].zero;
  assign saturated_o = lane_res[0].sat || lane_res[1].sat || lane_res[2].sat;

endmodule
`default_nettype wire

### design/qvr_checker.sv
// Port-level assertions for the quaternion vector rotation core, and their bind.
`default_nettype none
module qvr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_x_o,
  input wire logic [31:0] out_y_o,
  input wire logic [31:0] out_z_o,
  input wire logic        zero_norm_o,
  input wire logic        saturated_o
);

  // A zero-norm item carries a zero vector
  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |-> out_x_o == '0 && out_y_o == '0 && out_z_o == '0)
    else $error("zero-norm item with nonzero vector");

  // Zero norm never reports clamping
  a_zero_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_norm_o |-> !saturated_o)
    else $error("zero-norm item flagged saturated");

  // Input side opens exactly when the output slot can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready out of step with output stall");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o)
      && $stable(out_y_o) && $stable(out_z_o) && $stable(saturated_o))
    else $error("stalled item changed");

endmodule

bind quaternion_vector_rotation_core qvr_checker u_qvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_x_o     (out_x_o),
  .out_y_o     (out_y_o),
  .out_z_o     (out_z_o),
  .zero_norm_o (zero_norm_o),
  .saturated_o (saturated_o)
);
`default_nettype wire
